/* rtl/trv_pkg.sv */
// shared types, record layout constants and crc update for the tag record validator
package trv_pkg;

  // crc spans and record layout (byte offsets)
  localparam int CRC_SPAN       = 36;
  localparam int OLD_CRC_SPAN   = 20;
  localparam int STORE_BYTES    = CRC_SPAN + 2;
  localparam int POS_MAGIC      = 0;
  localparam int POS_CAGE       = 2;
  localparam int POS_CAGE_UNIT  = 4;
  localparam int POS_DOLLY      = 16;
  localparam int POS_DOLLY_UNIT = 18;
  localparam int POS_STAMP      = 32;
  localparam int POS_OLD_CRC    = 'h14;
  localparam int POS_MAIN_CRC   = CRC_SPAN;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // result classification
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_BLANK   = 2'd1,
    ST_OLD_V1  = 2'd2,
    ST_CORRUPT = 2'd3
  } status_e;

  // one result word, last member in the lowest bits
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] dolly_unit_high;
    logic [63:0] dolly_unit_low;
    logic        has_dolly;
    logic [15:0] dolly_number;
    logic [31:0] cage_unit_high;
    logic [63:0] cage_unit_low;
    logic [15:0] cage_number;
    status_e     status;
  } result_t;

  // msb-first crc-16 over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/trv_decode.sv */
// classification and field extraction from the captured record bytes
module trv_decode
  import trv_pkg::*;
(
  input  logic [7:0]  store_i [STORE_BYTES],
  input  logic [7:0]  magic_first_i,
  input  logic [7:0]  magic_second_i,
  input  logic [15:0] old_crc_i,
  input  logic [15:0] main_crc_i,
  output result_t     result_o
);

  logic        magic_ok;
  logic        main_ok;
  logic        old_ok;
  logic [15:0] dolly_no;

  // crc and magic checks
  assign magic_ok = (store_i[POS_MAGIC] == magic_first_i) &&
                    (store_i[POS_MAGIC + 1] == magic_second_i);
  assign main_ok  = {store_i[POS_MAIN_CRC + 1], store_i[POS_MAIN_CRC]} == main_crc_i;
  assign old_ok   = {store_i[POS_OLD_CRC + 1], store_i[POS_OLD_CRC]} == old_crc_i;
  assign dolly_no = {store_i[POS_DOLLY + 1], store_i[POS_DOLLY]};

  // fields are zero unless the record is valid
  always_comb begin
    result_o = '0;
    if (!magic_ok) begin
      result_o.status = ST_BLANK;
    end else if (main_ok) begin
      result_o.status = ST_VALID;
    end else if (old_ok) begin
      result_o.status = ST_OLD_V1;
    end else begin
      result_o.status = ST_CORRUPT;
    end

    if (result_o.status == ST_VALID) begin
      result_o.cage_number    = {store_i[POS_CAGE + 1], store_i[POS_CAGE]};
      for (int i = 0; i < 8; i++) begin
        result_o.cage_unit_low[8*i +: 8] = store_i[POS_CAGE_UNIT + i];
      end
      // last text byte forced to zero
      result_o.cage_unit_high = {8'h00, store_i[POS_CAGE_UNIT + 10],
                                 store_i[POS_CAGE_UNIT + 9], store_i[POS_CAGE_UNIT + 8]};
      result_o.dolly_number   = dolly_no;
      if (dolly_no != 16'h0000) begin
        result_o.has_dolly = 1'b1;
        for (int i = 0; i < 8; i++) begin
          result_o.dolly_unit_low[8*i +: 8] = store_i[POS_DOLLY_UNIT + i];
        end
        result_o.dolly_unit_high = {8'h00, store_i[POS_DOLLY_UNIT + 10],
                                    store_i[POS_DOLLY_UNIT + 9], store_i[POS_DOLLY_UNIT + 8]};
      end
      result_o.stamp = {store_i[POS_STAMP + 3], store_i[POS_STAMP + 2],
                        store_i[POS_STAMP + 1], store_i[POS_STAMP]};
    end
  end

endmodule

/* rtl/tag_record_validator_top.sv */
// top level of the tag record validator: byte capture, crc tracking and result register
//
// Usage: record bytes enter on the s_axis channel in address order, one word per
// byte; tuser marks byte 0 and restarts the position count and the crc. After
// RECORD_BYTES bytes the position wraps, so the next byte starts a new record
// even without a mark. A record cut short by a new mark gives no result.
// One result word leaves on m_axis for every complete record, carrying the
// status (valid, blank, old v1 format, corrupt) and the decoded fields.
// Throughput: one byte per cycle while s_axis_tready_o is high; the crc byte update is combinational.
// Latency: the result is valid in the cycle after the last byte is accepted.
// The result sits in an output register; while it waits and the receiver
// holds off, s_axis_tready_o is low and no byte is taken.
// The magic registers are to be written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// only while the block is idle; the block does not enforce this. Reset clears
// position, crcs, magic registers and the output valid; stored bytes are not cleared.
module tag_record_validator_top
  import trv_pkg::*;
#(
  parameter int RECORD_BYTES = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [7:0]   cfg_wdata_i,
  // input bytes
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tuser_i,   // start_of_record
  // results
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status, cage_number, cage_unit_low, cage_unit_high, dolly_number,
  // has_dolly, dolly_unit_low, dolly_unit_high, stamp, zero pad
  output logic [263:0] m_axis_tdata_o
);

  localparam int PosW = $clog2(RECORD_BYTES);
  localparam logic [0:0] REG_MAGIC_FIRST  = 1'b0;
  localparam logic [0:0] REG_MAGIC_SECOND = 1'b1;

  logic [7:0]      magic_first_q, magic_second_q;
  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [15:0]     crc_q, crc_d, crc_base, crc_next;
  logic [15:0]     old_crc_q, old_crc_d, main_crc_q, main_crc_d;
  logic [7:0]      store_q [STORE_BYTES];
  logic            in_acc, is_last;
  logic            out_valid_q;
  result_t         out_data_q, result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= 8'h00;
      magic_second_q <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAGIC_FIRST:  magic_first_q  <= cfg_wdata_i;
        REG_MAGIC_SECOND: magic_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake: the output register frees up when taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // position and crc for the incoming byte
  always_comb begin
    if (s_axis_tuser_i || ({1'b0, pos_q} >= (PosW+1)'(RECORD_BYTES))) begin
      pos_eff = '0;
    end else begin
      pos_eff = pos_q;
    end
    crc_base = s_axis_tuser_i ? CRC_INIT : crc_q;
    crc_next = crc_byte(crc_base, s_axis_tdata_i);
    is_last  = pos_eff == PosW'(RECORD_BYTES - 1);

    crc_d      = (pos_eff < PosW'(CRC_SPAN)) ? crc_next : crc_base;
    old_crc_d  = (pos_eff == PosW'(OLD_CRC_SPAN - 1)) ? crc_d : old_crc_q;
    main_crc_d = (pos_eff == PosW'(CRC_SPAN - 1)) ? crc_d : main_crc_q;
    pos_d      = pos_eff + 1'b1;
    if (is_last) begin
      pos_d = '0;
      crc_d = CRC_INIT;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      crc_q      <= CRC_INIT;
      old_crc_q  <= CRC_INIT;
      main_crc_q <= CRC_INIT;
    end else if (in_acc) begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      old_crc_q  <= old_crc_d;
      main_crc_q <= main_crc_d;
    end
  end

  // record byte capture, the first STORE_BYTES bytes (up to and including the main crc)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        if (pos_eff == PosW'(i)) begin
          store_q[i] <= s_axis_tdata_i;
        end
      end
    end
  end

  trv_decode u_decode (
    .store_i        (store_q),
    .magic_first_i  (magic_first_q),
    .magic_second_i (magic_second_q),
    .old_crc_i      (old_crc_q),
    .main_crc_i     (main_crc_q),
    .result_o       (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && is_last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_last) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_data_q};

`ifndef ASSERT_OFF
  // a result only appears after the last byte of a record
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && is_last))
    else $error("result without a completed record");

  // position stays within the record
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (PosW+1)'(RECORD_BYTES))
    else $error("byte position out of range");

  // a finished record restarts position and crc
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_last) |=> (pos_q == '0) && (crc_q == CRC_INIT))
    else $error("record end did not restart position and crc");

  // only a valid record carries fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.status != ST_VALID)) |->
      (out_data_q[$bits(result_t)-1:2] == '0))
    else $error("fields not zero on a record that is not valid");

  // dolly flag agrees with the dolly number
  a_dolly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.has_dolly) |->
      ((out_data_q.dolly_number != 16'h0000) && (out_data_q.status == ST_VALID)))
    else $error("dolly flag without a dolly number");
`endif

endmodule

/* test/tag_record_validator_top_test.sv */
// self-checking testbench for the tag record validator: random and directed records, checked per word
module tag_record_validator_top_test
  import trv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECORD_BYTES = 40;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_SPACING = 900;

  // register indexes of the configuration port
  localparam logic [0:0] REG_MAGIC_FIRST  = 1'b0;
  localparam logic [0:0] REG_MAGIC_SECOND = 1'b1;

  typedef enum int {REC_VALID, REC_BLANK, REC_OLD_V1, REC_CORRUPT, REC_BOTH_CRC} rec_kind_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct {
    logic [7:0] data;
    logic       mark;
  } byte_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_idx = REG_MAGIC_FIRST;
  logic [7:0]   cfg_wdata = 8'h00;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [7:0]   s_data = 8'h00;
  logic         s_user = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [263:0] m_data;

  tag_record_validator_top #(
    .RECORD_BYTES(RECORD_BYTES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and checking state
  byte_word_t byte_q[$];
  result_t    outcome_q[$];
  int         bytes_queued = 0;
  int         bytes_in = 0;
  int         results_seen = 0;
  int         status_seen[4] = '{0, 0, 0, 0};
  int         fail_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  int         next_hold_at = 500;
  int         quiet = 0;
  logic       byte_taken = 1'b0;
  bit         calm = 1'b0;

  // predictor state
  logic [7:0]  magic_first_r = 8'h00;
  logic [7:0]  magic_second_r = 8'h00;
  int          rec_pos = 0;
  logic [15:0] run_crc = 16'h0000;
  logic [15:0] old_crc = 16'h0000;
  logic [15:0] main_crc = 16'h0000;
  logic [7:0]  rec_mem [0:RECORD_BYTES-1];

  // msb-first crc-16, one data bit at a time
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic [15:0] crc_span(input logic [7:0] rec [0:RECORD_BYTES-1], input int n);
    logic [15:0] crc;
    crc = 16'h0000;
    for (int i = 0; i < n; i++) begin
      crc = crc16_step(crc, rec[i]);
    end
    return crc;
  endfunction

  function automatic logic [15:0] le16(input int pos);
    return {rec_mem[pos+1], rec_mem[pos]};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // predictor: take one byte, queue the result word when a record completes
  task automatic absorb_byte(input logic [7:0] b, input logic mark);
    int      p;
    result_t res;
    if (mark) begin
      rec_pos = 0;
      run_crc = 16'h0000;
    end
    p = (rec_pos >= RECORD_BYTES) ? 0 : rec_pos;
    rec_mem[p] = b;
    if (p < CRC_SPAN) run_crc = crc16_step(run_crc, b);
    if (p == OLD_CRC_SPAN - 1) old_crc = run_crc;
    if (p == CRC_SPAN - 1) main_crc = run_crc;
    if (p != RECORD_BYTES - 1) begin
      rec_pos = p + 1;
      return;
    end
    rec_pos = 0;
    run_crc = 16'h0000;
    res = '0;
    if (rec_mem[POS_MAGIC] != magic_first_r || rec_mem[POS_MAGIC+1] != magic_second_r) begin
      res.status = ST_BLANK;
    end else if (le16(POS_MAIN_CRC) == main_crc) begin
      res.status = ST_VALID;
    end else if (le16(POS_OLD_CRC) == old_crc) begin
      res.status = ST_OLD_V1;
    end else begin
      res.status = ST_CORRUPT;
    end
    if (res.status == ST_VALID) begin
      res.cage_number  = le16(POS_CAGE);
      res.dolly_number = le16(POS_DOLLY);
      res.has_dolly    = (res.dolly_number != 16'h0000);
      for (int i = 0; i < 8; i++) begin
        res.cage_unit_low[8*i +: 8] = rec_mem[POS_CAGE_UNIT+i];
        if (res.has_dolly) res.dolly_unit_low[8*i +: 8] = rec_mem[POS_DOLLY_UNIT+i];
      end
      // last text byte stays zero
      for (int i = 0; i < 3; i++) begin
        res.cage_unit_high[8*i +: 8] = rec_mem[POS_CAGE_UNIT+8+i];
        if (res.has_dolly) res.dolly_unit_high[8*i +: 8] = rec_mem[POS_DOLLY_UNIT+8+i];
      end
      for (int i = 0; i < 4; i++) begin
        res.stamp[8*i +: 8] = rec_mem[POS_STAMP+i];
      end
    end
    outcome_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: byte handshakes feed the predictor, result words are checked
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      byte_taken <= s_valid && s_ready;
      if (s_valid && s_ready) begin
        bytes_in <= bytes_in + 1;
        absorb_byte(s_data, s_user);
      end
      if (m_valid && m_ready) begin
        got = m_data[$bits(result_t)-1:0];
        if (outcome_q.size() == 0) begin
          $error("result word with no record pending, status %0d", got.status);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          results_seen++;
          status_seen[want.status]++;
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("cage_number", 64'(want.cage_number), 64'(got.cage_number));
          check_field("cage_unit_low", want.cage_unit_low, got.cage_unit_low);
          check_field("cage_unit_high", 64'(want.cage_unit_high), 64'(got.cage_unit_high));
          check_field("dolly_number", 64'(want.dolly_number), 64'(got.dolly_number));
          check_field("has_dolly", 64'(want.has_dolly), 64'(got.has_dolly));
          check_field("dolly_unit_low", want.dolly_unit_low, got.dolly_unit_low);
          check_field("dolly_unit_high", 64'(want.dolly_unit_high),
                      64'(got.dolly_unit_high));
          check_field("stamp", 64'(want.stamp), 64'(got.stamp));
        end
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin : driver
    byte_word_t nxt;
    if (!s_valid || byte_taken) begin
      if (send_gap != 0) begin
        s_valid  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        s_valid  <= 1'b1;
        s_data   <= nxt.data;
        s_user   <= nxt.mark;
        send_gap <= calm ? 0 : pick_gap();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0 || recv_gap != 0) begin
      m_ready <= 1'b0;
      if (recv_gap != 0) recv_gap <= recv_gap - 1;
    end else begin
      m_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) recv_gap <= pick_gap();
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (bytes_in >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic mark);
    byte_word_t w;
    w.data = b;
    w.mark = mark;
    byte_q.push_back(w);
    bytes_queued++;
  endtask

  // build one whole record of the given kind and queue its bytes
  task automatic push_record(input rec_kind_e kind, input fill_e fill, input int dolly_val,
                             input bit mark);
    logic [7:0]  rec [0:RECORD_BYTES-1];
    logic [15:0] v1;
    logic [15:0] crc;
    int          wrong;
    for (int i = 0; i < RECORD_BYTES; i++) begin
      case (fill)
        FILL_ZERO: rec[i] = 8'h00;
        FILL_ONES: rec[i] = 8'hff;
        default:   rec[i] = 8'($urandom_range(0, 255));
      endcase
    end
    rec[POS_MAGIC]   = magic_first_r;
    rec[POS_MAGIC+1] = magic_second_r;
    // blank: spoil one or both magic bytes, main crc still made to match
    if (kind == REC_BLANK) begin
      wrong = $urandom_range(1, 3);
      if (wrong[0]) rec[POS_MAGIC] = rec[POS_MAGIC] ^ 8'($urandom_range(1, 255));
      if (wrong[1]) rec[POS_MAGIC+1] = rec[POS_MAGIC+1] ^ 8'($urandom_range(1, 255));
    end
    if (dolly_val >= 0) {rec[POS_DOLLY+1], rec[POS_DOLLY]} = dolly_val[15:0];
    v1 = crc_span(rec, OLD_CRC_SPAN);
    if (kind == REC_OLD_V1 || kind == REC_BOTH_CRC) begin
      {rec[POS_OLD_CRC+1], rec[POS_OLD_CRC]} = v1;
    end else if (kind == REC_CORRUPT) begin
      {rec[POS_OLD_CRC+1], rec[POS_OLD_CRC]} = v1 ^ 16'($urandom_range(1, 65535));
    end
    crc = crc_span(rec, CRC_SPAN);
    if (kind == REC_OLD_V1 || kind == REC_CORRUPT) crc = crc ^ 16'($urandom_range(1, 65535));
    {rec[POS_MAIN_CRC+1], rec[POS_MAIN_CRC]} = crc;
    for (int i = 0; i < RECORD_BYTES; i++) begin
      push_byte(rec[i], (i == 0) ? mark : 1'b0);
    end
  endtask

  // random bytes, possibly with stray start marks
  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(0, 255)),
                (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0));
    end
  endtask

  // wait until every byte is taken and every result checked
  task automatic wait_idle();
    while (bytes_in != bytes_queued || outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // write both magic registers back to back, called at a falling edge
  task automatic set_magic(input logic [7:0] first, input logic [7:0] second);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MAGIC_FIRST;
    cfg_wdata <= first;
    @(negedge clk_i);
    cfg_idx   <= REG_MAGIC_SECOND;
    cfg_wdata <= second;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    magic_first_r  = first;
    magic_second_r = second;
    @(posedge clk_i);
  endtask

  // mostly well-formed records with random content, some noise and cut records
  task automatic random_phase(input int records);
    bit        need_mark;
    int        r;
    rec_kind_e kind;
    need_mark = 1'b1;
    repeat (records) begin
      if ($urandom_range(0, 99) < 15) begin
        push_noise($urandom_range(1, 50));
        need_mark = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 55) kind = REC_VALID;
      else if (r < 70) kind = REC_BLANK;
      else if (r < 82) kind = REC_OLD_V1;
      else if (r < 92) kind = REC_CORRUPT;
      else kind = REC_BOTH_CRC;
      push_record(kind, FILL_RANDOM, ($urandom_range(0, 3) == 0) ? 0 : -1,
                  need_mark || $urandom_range(0, 1));
      need_mark = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed records at the reset magic values
    push_record(REC_VALID, FILL_ZERO, -1, 1'b1);
    push_record(REC_VALID, FILL_ONES, -1, 1'b0);
    push_record(REC_VALID, FILL_RANDOM, 0, 1'b1);
    push_record(REC_VALID, FILL_RANDOM, 'h100, 1'b0);
    push_record(REC_VALID, FILL_RANDOM, 1, 1'b1);
    push_record(REC_BLANK, FILL_RANDOM, -1, 1'b1);
    push_record(REC_OLD_V1, FILL_RANDOM, -1, 1'b0);
    push_record(REC_CORRUPT, FILL_RANDOM, -1, 1'b1);
    push_record(REC_BOTH_CRC, FILL_ONES, -1, 1'b1);
    // record cut short by a new start mark
    for (int i = 0; i < 17; i++) push_byte(8'($urandom_range(0, 255)), i == 0);
    push_record(REC_VALID, FILL_RANDOM, -1, 1'b1);
    wait_idle();

    set_magic(8'hff, 8'hff);
    push_record(REC_VALID, FILL_ONES, -1, 1'b1);
    push_record(REC_BLANK, FILL_ONES, -1, 1'b0);
    random_phase(7);

    set_magic(8'h5a, 8'ha5);
    calm = 1'b1;
    random_phase(7);
    calm = 1'b0;

    set_magic(8'h00, 8'hff);
    random_phase(7);

    set_magic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_phase(7);

    repeat (10) @(negedge clk_i);
    $display("covered %0d bytes and %0d records: valid %0d, blank %0d, old v1 %0d, corrupt %0d",
             bytes_in, results_seen, status_seen[ST_VALID], status_seen[ST_BLANK],
             status_seen[ST_OLD_V1], status_seen[ST_CORRUPT]);
    $display("five magic settings, random gaps on both sides, long receiver hold-offs");
    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/trv_pkg.sv
rtl/trv_decode.sv
rtl/tag_record_validator_top.sv
test/tag_record_validator_top_test.sv
